// ===== hdl/urt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_pkg: shared types and constants of the ultrasonic echo ranger
// Widths, register layout, controller states, and the command and status
// structs that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package urt_pkg;

	// sizing
	localparam int COUNT_WIDTH = 24;
	localparam int DIST_WIDTH  = 10;
	localparam int CM_W        = 10;                 // near/far register width
	localparam int OFF_W       = (DIST_WIDTH > CM_W) ? DIST_WIDTH : CM_W;
	localparam int PROD_W      = OFF_W + 8;
	localparam int DIV_W       = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;
	localparam int DEN_W       = 16;
	localparam int STEP_W      = $clog2(DIV_W + 1);
	localparam int CMP_W       = 34;                 // common compare width

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = '1;
	localparam logic [DIST_WIDTH-1:0]  DIST_MAX = '1;

	// tone mapping
	localparam logic [7:0] TONE_MIN  = 8'd33;
	localparam logic [7:0] TONE_SPAN = 8'd222;
	localparam logic [7:0] TONE_MAX  = 8'd255;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TRIG_HIGH = 3'd0,
		REG_GUARD     = 3'd1,
		REG_TIMEOUT   = 3'd2,
		REG_TICKS_CM  = 3'd3,
		REG_NEAR      = 3'd4,
		REG_FAR       = 3'd5,
		REG_REBOOT    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]     trig_high_ticks;
		logic [15:0]     guard_ticks;
		logic [23:0]     timeout_ticks;
		logic [15:0]     ticks_per_cm;
		logic [CM_W-1:0] near_cm;
		logic [CM_W-1:0] far_cm;
		logic [15:0]     reboot_ticks;
	} cfg_t;

	// item stream
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_BITS    = 14 + DIST_WIDTH;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		STAT_OK      = 2'd0,
		STAT_NO_ECHO = 2'd1,
		STAT_STUCK   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GUARD1,
		ST_HIGH,
		ST_GUARD2,
		ST_WAIT,
		ST_MEAS,
		ST_REBOOT,
		ST_DDIV,
		ST_TSEL,
		ST_TDIV
	} state_t;

	typedef enum logic [1:0] {CNT_HOLD, CNT_CLEAR, CNT_INC} cnt_op_t;
	typedef enum logic [1:0] {LIM_GUARD, LIM_TRIG, LIM_REBOOT} lim_sel_t;
	typedef enum logic [1:0] {TONE_HOLD, TONE_OFF, TONE_FIXED, TONE_DIV} tone_op_t;
	typedef enum logic {DIV_DIST, DIV_TONE} div_sel_t;

	typedef struct packed {
		cnt_op_t  cnt_op;
		logic     cnt_zero;     // count from zero this tick
		lim_sel_t lim_sel;
		logic     div_start;
		div_sel_t div_sel;
		logic     dist_load;
		tone_op_t tone_op;
	} dp_cmd_t;

	typedef struct packed {
		logic lim_hit;
		logic tmo_hit;
		logic div_done;
		logic dist_ge_far;
		logic lim_unordered;
	} dp_sts_t;

	typedef struct packed {
		logic    trig;
		logic    power;
		logic    busy;
		logic    done;
		status_t status;
		logic    dist_en;
	} res_info_t;

	typedef struct packed {
		logic [7:0]            tone_period;
		logic                  tone_enable;
		logic [DIST_WIDTH-1:0] distance_cm;
		status_t               status;
		logic                  done_res;
		logic                  busy_res;
		logic                  sensor_power;
		logic                  trig_level;
	} result_t;

endpackage
`default_nettype wire

// ===== hdl/ultrasonic_echo_ranger_with_tone.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_with_tone: echo-pulse ranger with proximity tone
// Trigger pulse, echo timing, distance and tone period for an ultrasonic
// range sensor, driven one tick item at a time.
// ----------------------------------------------------------------------------
// Each input item is one tick: start request and sampled echo level. Every
// accepted tick gives exactly one result item on the master side. Ticks are
// taken one per cycle while the result queue has room, except the tick on
// which the echo falls: that one closes a good measurement and its result
// comes out only after the shared restoring divider has run, which yields
// one quotient bit per cycle first for centimetres and then, when a tone is
// due, for the tone period. The slave side is not ready until that result
// has been pushed. A two-entry result queue sits in front of the master
// side, so ticks keep flowing while one result waits to be taken.
// Configuration writes are taken at any time but should only be issued while
// no measurement is running.
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_with_tone
	import urt_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,

	// tick items
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [0] start_req, [1] echo

	// result items
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // [0] trig_level, [1] sensor_power,
	                                               // [2] busy_res, [4:3] status,
	                                               // [14:5] distance_cm, [15] tone_enable,
	                                               // [23:16] tone_period
	output logic                        m_tlast,   // done_res: measurement finished

	// register writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t                  cfg_q;
	dp_cmd_t               cmd;
	dp_sts_t               sts;
	res_info_t             info;
	logic                  tick_ok;
	logic                  acc;
	logic                  res_push;
	logic [DIST_WIDTH-1:0] dist_cm;
	logic                  tone_on_nx;
	logic [7:0]            tone_val_nx;

	// result queue
	result_t               rq_q [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;
	logic                  pop;
	result_t               res_new;

	// ---- configuration registers ----
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trig_high_ticks <= 16'd192;
			cfg_q.guard_ticks     <= 16'd16;
			cfg_q.timeout_ticks   <= 24'd466472;
			cfg_q.ticks_per_cm    <= 16'd928;
			cfg_q.near_cm         <= CM_W'(20);
			cfg_q.far_cm          <= CM_W'(60);
			cfg_q.reboot_ticks    <= 16'd3200;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_idx_t'(cfg_index))
				REG_TRIG_HIGH: cfg_q.trig_high_ticks <= cfg_data[15:0];
				REG_GUARD:     cfg_q.guard_ticks     <= cfg_data[15:0];
				REG_TIMEOUT:   cfg_q.timeout_ticks   <= cfg_data[23:0];
				REG_TICKS_CM:  cfg_q.ticks_per_cm    <= cfg_data[15:0];
				REG_NEAR:      cfg_q.near_cm         <= cfg_data[CM_W-1:0];
				REG_FAR:       cfg_q.far_cm          <= cfg_data[CM_W-1:0];
				REG_REBOOT:    cfg_q.reboot_ticks    <= cfg_data[15:0];
				default:       cfg_q                 <= cfg_q;   // unmapped index
			endcase
		end
	end

	// ---- tick intake ----
	// a tick needs a free queue slot, or one freed this cycle
	assign pop      = m_tvalid && m_tready;
	assign s_tready = tick_ok && ((fill_q != 2'd2) || m_tready);
	assign acc      = s_tvalid && s_tready;

	urt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.start_req (s_tdata[0]),
		.echo      (s_tdata[1]),
		.sts       (sts),
		.cmd       (cmd),
		.tick_ok   (tick_ok),
		.res_push  (res_push),
		.res       (info)
	);

	urt_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.sts         (sts),
		.dist_cm     (dist_cm),
		.tone_on_nx  (tone_on_nx),
		.tone_val_nx (tone_val_nx)
	);

	// ---- result assembly ----
	always_comb begin
		res_new.trig_level   = info.trig;
		res_new.sensor_power = info.power;
		res_new.busy_res     = info.busy;
		res_new.done_res     = info.done;
		res_new.status       = info.status;
		res_new.distance_cm  = info.dist_en ? dist_cm : '0;
		res_new.tone_enable  = tone_on_nx;
		res_new.tone_period  = tone_val_nx;
	end

	// ---- two-entry result queue ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (res_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({res_push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			rq_q[wr_ptr_q] <= res_new;
		end
	end

	assign m_tvalid = (fill_q != 2'd0);
	assign m_tdata  = OUT_TDATA_W'({rq_q[rd_ptr_q].tone_period,
	                                rq_q[rd_ptr_q].tone_enable,
	                                rq_q[rd_ptr_q].distance_cm,
	                                rq_q[rd_ptr_q].status,
	                                rq_q[rd_ptr_q].busy_res,
	                                rq_q[rd_ptr_q].sensor_power,
	                                rq_q[rd_ptr_q].trig_level});
	assign m_tlast  = rq_q[rd_ptr_q].done_res;

	// queue never overfills: a push into a full queue must coincide with a pop
	a_rq_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && fill_q == 2'd2) |-> pop)
		else $error("result queue overflow");

	// fill count stays within the two entries
	a_rq_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("result queue fill out of range");

	// an accepted tick that yields no result now must leave the slave side not ready
	a_tick_push: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !res_push) |=> !tick_ok)
		else $error("tick item dropped without result");

endmodule
`default_nettype wire

// ===== hdl/urt_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_div: restoring divider
// Unsigned quotient, one bit per cycle while busy.
// ----------------------------------------------------------------------------
module urt_div
	import urt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DEN_W-1:0] divisor,
	output logic                  busy,
	output logic      [DIV_W-1:0] quotient
);

	logic [DEN_W-1:0]  rem_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [DEN_W:0]    rem_sh;
	logic              ge;
	logic [DEN_W:0]    rem_sub;

	always_comb begin
		rem_sh  = {rem_q, quo_q[DIV_W-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(DIV_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

// ===== hdl/urt_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_dpath: ranger datapath
// Tick counter with limit and timeout compares, shared divider for distance
// and tone, distance register and tone registers.
// ----------------------------------------------------------------------------
module urt_dpath
	import urt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire cfg_t                  cfg,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts,
	output logic [DIST_WIDTH-1:0]      dist_cm,
	output logic                       tone_on_nx,
	output logic [7:0]                 tone_val_nx
);

	logic [COUNT_WIDTH-1:0] cnt_q;
	logic [DIST_WIDTH-1:0]  dist_q;
	logic                   tone_on_q;
	logic [7:0]             tone_val_q;

	logic [COUNT_WIDTH-1:0] cnt_eff;
	logic [COUNT_WIDTH:0]   cnt_inc;
	logic [15:0]            lim;

	logic [OFF_W-1:0]       dist_x;
	logic [OFF_W-1:0]       near_x;
	logic [OFF_W-1:0]       far_x;
	logic [OFF_W-1:0]       off;
	logic [CM_W-1:0]        span;
	logic [PROD_W-1:0]      prod;

	logic                   div_start;
	logic [DIV_W-1:0]       div_num;
	logic [DEN_W-1:0]       div_den;
	logic                   div_busy;
	logic [DIV_W-1:0]       div_quo;
	logic [7:0]             tone_calc;

	// counter compares
	always_comb begin
		cnt_eff = cmd.cnt_zero ? '0 : cnt_q;
		cnt_inc = {1'b0, cnt_eff} + (COUNT_WIDTH+1)'(1);
		unique case (cmd.lim_sel)
			LIM_GUARD:  lim = cfg.guard_ticks;
			LIM_TRIG:   lim = cfg.trig_high_ticks;
			LIM_REBOOT: lim = cfg.reboot_ticks;
			default:    lim = cfg.guard_ticks;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case (cmd.cnt_op)
				CNT_CLEAR: cnt_q <= '0;
				CNT_INC:   cnt_q <= (cnt_eff == CNT_MAX) ? CNT_MAX
				                                         : cnt_inc[COUNT_WIDTH-1:0];
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	// tone operands
	always_comb begin
		dist_x = OFF_W'(dist_q);
		near_x = OFF_W'(cfg.near_cm);
		far_x  = OFF_W'(cfg.far_cm);
		off    = (dist_x < near_x) ? '0 : dist_x - near_x;
		span   = cfg.far_cm - cfg.near_cm;
		prod   = PROD_W'(off) * PROD_W'(TONE_SPAN);
	end

	// divider feed: echo ticks over ticks-per-cm, or scaled offset over span
	always_comb begin
		div_start = cmd.div_start;
		if (cmd.div_sel == DIV_DIST) begin
			div_num = DIV_W'(cnt_q);
			div_den = (cfg.ticks_per_cm == '0) ? DEN_W'(1) : DEN_W'(cfg.ticks_per_cm);
		end else begin
			div_num = DIV_W'(prod);
			div_den = DEN_W'(span);
		end
	end

	urt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.dist_load) begin
			dist_q <= (div_quo > DIV_W'(DIST_MAX)) ? DIST_MAX : div_quo[DIST_WIDTH-1:0];
		end
	end

	// tone registers; the item result carries the post-tick values
	always_comb begin
		tone_calc = (div_quo > DIV_W'(TONE_MAX - TONE_MIN)) ? TONE_MAX
		                                                   : TONE_MIN + div_quo[7:0];
		tone_on_nx  = tone_on_q;
		tone_val_nx = tone_val_q;
		case (cmd.tone_op)
			TONE_OFF: begin
				tone_on_nx = 1'b0;
			end
			TONE_FIXED: begin
				tone_on_nx  = 1'b1;
				tone_val_nx = TONE_MIN;
			end
			TONE_DIV: begin
				tone_on_nx  = 1'b1;
				tone_val_nx = tone_calc;
			end
			default: begin
				tone_on_nx = tone_on_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_on_q  <= 1'b0;
			tone_val_q <= TONE_MIN;
		end else begin
			tone_on_q  <= tone_on_nx;
			tone_val_q <= tone_val_nx;
		end
	end

	always_comb begin
		sts.lim_hit       = CMP_W'(cnt_inc) >= CMP_W'(lim);
		sts.tmo_hit       = (CMP_W'(cnt_eff) >= CMP_W'(cfg.timeout_ticks)) ||
		                    (cnt_eff == CNT_MAX);
		sts.div_done      = !div_busy;
		sts.dist_ge_far   = dist_x >= far_x;
		sts.lim_unordered = cfg.far_cm <= cfg.near_cm;
	end

	assign dist_cm = dist_q;

endmodule
`default_nettype wire

// ===== hdl/urt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// urt_ctrl: ranger controller
// Measurement phase machine plus the divide sequence that closes a good
// measurement.
// ----------------------------------------------------------------------------
module urt_ctrl
	import urt_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      acc,        // tick item taken this cycle
	input  wire logic      start_req,
	input  wire logic      echo,
	input  wire dp_sts_t   sts,
	output dp_cmd_t        cmd,
	output logic           tick_ok,    // able to take a tick item
	output logic           res_push,
	output res_info_t      res
);

	state_t state_q;
	state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx      = state_q;
		cmd.cnt_op    = CNT_HOLD;
		cmd.cnt_zero  = 1'b0;
		cmd.lim_sel   = LIM_GUARD;
		cmd.div_start = 1'b0;
		cmd.div_sel   = DIV_DIST;
		cmd.dist_load = 1'b0;
		cmd.tone_op   = TONE_HOLD;
		tick_ok       = 1'b1;
		res_push      = 1'b0;
		res.trig      = 1'b0;
		res.power     = 1'b1;
		res.busy      = 1'b1;
		res.done      = 1'b0;
		res.status    = STAT_OK;
		res.dist_en   = 1'b0;

		unique case (state_q)
			ST_IDLE, ST_GUARD1, ST_HIGH, ST_GUARD2, ST_REBOOT: begin
				// timed phases; a start from idle runs the first guard tick at once
				res_push     = acc;
				cmd.cnt_zero = (state_q == ST_IDLE);
				res.trig     = (state_q == ST_HIGH);
				res.power    = (state_q != ST_REBOOT);
				if (state_q == ST_HIGH) begin
					cmd.lim_sel = LIM_TRIG;
				end else if (state_q == ST_REBOOT) begin
					cmd.lim_sel = LIM_REBOOT;
				end
				if (state_q == ST_IDLE && !start_req) begin
					res.busy = 1'b0;
				end else if (acc) begin
					cmd.cnt_op = sts.lim_hit ? CNT_CLEAR : CNT_INC;
					if (sts.lim_hit) begin
						unique case (state_q)
							ST_IDLE:   state_nx = ST_HIGH;
							ST_GUARD1: state_nx = ST_HIGH;
							ST_HIGH:   state_nx = ST_GUARD2;
							ST_GUARD2: state_nx = ST_WAIT;
							default:   state_nx = ST_IDLE;
						endcase
					end else if (state_q == ST_IDLE) begin
						state_nx = ST_GUARD1;
					end
				end
			end
			ST_WAIT, ST_MEAS: begin
				// echo high counts from zero on the rise tick
				cmd.cnt_zero = (state_q == ST_WAIT) && echo;
				if (acc) begin
					if (state_q == ST_MEAS && !echo) begin
						cmd.div_start = 1'b1;
						cmd.cnt_op    = CNT_CLEAR;
						state_nx      = ST_DDIV;
					end else begin
						res_push = 1'b1;
						if (sts.tmo_hit) begin
							cmd.cnt_op  = CNT_CLEAR;
							cmd.tone_op = TONE_OFF;
							res.done    = 1'b1;
							res.status  = echo ? STAT_STUCK : STAT_NO_ECHO;
							state_nx    = echo ? ST_REBOOT : ST_IDLE;
						end else begin
							cmd.cnt_op = CNT_INC;
							if (echo) begin
								state_nx = ST_MEAS;
							end
						end
					end
				end
			end
			ST_DDIV: begin
				tick_ok = 1'b0;
				if (sts.div_done) begin
					cmd.dist_load = 1'b1;
					state_nx      = ST_TSEL;
				end
			end
			ST_TSEL: begin
				tick_ok     = 1'b0;
				res.done    = 1'b1;
				res.dist_en = 1'b1;
				if (sts.dist_ge_far) begin
					cmd.tone_op = TONE_OFF;
					res_push    = 1'b1;
					state_nx    = ST_IDLE;
				end else if (sts.lim_unordered) begin
					cmd.tone_op = TONE_FIXED;
					res_push    = 1'b1;
					state_nx    = ST_IDLE;
				end else begin
					cmd.div_sel   = DIV_TONE;
					cmd.div_start = 1'b1;
					state_nx      = ST_TDIV;
				end
			end
			ST_TDIV: begin
				tick_ok     = 1'b0;
				res.done    = 1'b1;
				res.dist_en = 1'b1;
				if (sts.div_done) begin
					cmd.tone_op = TONE_DIV;
					res_push    = 1'b1;
					state_nx    = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// divider must be busy on the cycle after a start
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> !sts.div_done)
		else $error("divider not busy after start");

	// no tick item may be taken while a distance or tone divide is pending
	a_no_acc_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DDIV || state_q == ST_TSEL || state_q == ST_TDIV) |-> !acc)
		else $error("tick item taken during divide");

	// a non-final result always reports ok and no distance
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.done) |-> (res.status == STAT_OK && !res.dist_en))
		else $error("status set on a non-final result");

	// a good measurement whose result is pushed from tone selection returns to idle
	a_tsel_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TSEL && res_push) |=> (state_q == ST_IDLE))
		else $error("controller did not return to idle");

endmodule
`default_nettype wire
